// File: rtl/upe_pkg.sv
// ----------------------------------------------------------------------------
// upe_pkg
// Shared types, codes and character tables for the url percent encoder.
// ----------------------------------------------------------------------------
package upe_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned TOTAL_W   = 16;
  localparam int unsigned CAP_W     = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // command queue depth and pointer width
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = 1;
  localparam int unsigned QCNT_W    = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BY_LINE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd2;

  // encode modes
  localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXTENDED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALL      = 2'd2;

  // reset values
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd1024;

  // special characters
  localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_PCT       = 8'h25;
  localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] PRINT_LO       = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI       = 8'h7E;
  localparam logic [3:0]        NIBBLE_MASK    = 4'hF;

  // what the back end does with one accepted byte
  typedef enum logic [1:0] {
    CMD_DROP,
    CMD_PASS,
    CMD_ENCODE
  } cmd_kind_e;

  // character position within an encoded triple
  typedef enum logic [1:0] {
    PH_PCT,
    PH_HI,
    PH_LO
  } phase_e;

  // live configuration
  typedef struct packed {
    logic [MODE_W-1:0] encode_mode;
    logic              by_line;
    logic [CAP_W-1:0]  capacity;
  } cfg_t;

  // one queued command
  typedef struct packed {
    cmd_kind_e          kind;
    logic [CHAR_W-1:0]  data;
    logic [TOTAL_W-1:0] total1;
    logic [TOTAL_W-1:0] total2;
    logic [TOTAL_W-1:0] total3;
  } cmd_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // upper case hex digit
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

  // normal reserved set
  function automatic logic in_base_set(input logic [CHAR_W-1:0] c);
    logic hit;
    unique case (c)
      8'h3C, 8'h3E, 8'h22, 8'h23, 8'h25, 8'h7B, 8'h7D, 8'h7C,
      8'h5C, 8'h5E, 8'h7E, 8'h5B, 8'h5D, 8'h60, 8'h3B, 8'h2F,
      8'h3F, 8'h3A, 8'h40, 8'h3D, 8'h26, 8'h20: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // extra characters of the extended set
  function automatic logic in_ext_set(input logic [CHAR_W-1:0] c);
    logic hit;
    unique case (c)
      8'h21, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h24, 8'h2C: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// File: rtl/upe_in_if.sv
// ----------------------------------------------------------------------------
// upe_in_if
// Source byte channel: valid, ready and the byte with its start flag.
// ----------------------------------------------------------------------------
interface upe_in_if import upe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] data_byte;
  logic              start_of_text;

  modport source (output valid, output data_byte, output start_of_text, input ready);
  modport sink   (input valid, input data_byte, input start_of_text, output ready);
endinterface

// File: rtl/upe_out_if.sv
// ----------------------------------------------------------------------------
// upe_out_if
// Result channel: one emitted character per beat with its status.
// ----------------------------------------------------------------------------
interface upe_out_if import upe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  out_char;
  logic               last_of_run;
  logic               dropped;
  logic [TOTAL_W-1:0] stored_total;

  modport source (output valid, output out_char, output last_of_run, output dropped,
                  output stored_total, input ready);
  modport sink   (input valid, input out_char, input last_of_run, input dropped,
                  input stored_total, output ready);
endinterface

// File: rtl/upe_cfg_if.sv
// ----------------------------------------------------------------------------
// upe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface upe_cfg_if import upe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/upe_front.sv
// ----------------------------------------------------------------------------
// upe_front
// Accepts source bytes, checks room, classifies and keeps the stored count.
// ----------------------------------------------------------------------------
module upe_front import upe_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  upe_in_if.sink             in_i,
  input  q_stat_t            q_stat_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  localparam int unsigned CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS-1:0] plus1, plus2, plus3;
  logic [CMP_W-1:0]      need;
  logic                  room;
  logic                  printable;
  logic                  encode;
  logic [CHAR_W-1:0]     c;

  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && in_i.ready;
  assign c          = in_i.data_byte;

  // room check against capacity
  always_comb begin
    base  = in_i.start_of_text ? '0 : count_q;
    plus1 = base + COUNT_BITS'(1);
    plus2 = base + COUNT_BITS'(2);
    plus3 = base + COUNT_BITS'(3);
    need  = CMP_W'(base) + CMP_W'(2);
    room  = need < CMP_W'(cfg_i.capacity);
  end

  // classification
  always_comb begin
    printable = (c >= PRINT_LO) && (c <= PRINT_HI);
    priority if (cfg_i.by_line && (c == CHAR_CR || c == CHAR_LF)) begin
      encode = 1'b0;
    end else if (cfg_i.encode_mode == MODE_ALL) begin
      encode = 1'b1;
    end else if (!printable) begin
      encode = 1'b1;
    end else if (in_base_set(c)) begin
      encode = 1'b1;
    end else if (cfg_i.encode_mode == MODE_EXTENDED && in_ext_set(c)) begin
      encode = 1'b1;
    end else begin
      encode = 1'b0;
    end
  end

  // command and next count
  always_comb begin
    cmd_o.data   = c;
    cmd_o.total2 = TOTAL_W'(plus2);
    cmd_o.total3 = TOTAL_W'(plus3);
    priority if (!room) begin
      cmd_o.kind   = CMD_DROP;
      cmd_o.total1 = TOTAL_W'(base);
      count_d      = base;
    end else if (encode) begin
      cmd_o.kind   = CMD_ENCODE;
      cmd_o.total1 = TOTAL_W'(plus1);
      count_d      = plus3;
    end else begin
      cmd_o.kind   = CMD_PASS;
      cmd_o.total1 = TOTAL_W'(plus1);
      count_d      = plus1;
    end
  end

  // stored character count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_o) begin
      count_q <= count_d;
    end
  end

endmodule

// File: rtl/upe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// upe_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module upe_cmd_fifo import upe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_data_i,
  input  logic    pop_i,
  output cmd_t    head_o,
  output q_stat_t stat_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/upe_back.sv
// ----------------------------------------------------------------------------
// upe_back
// Walks queued commands and emits one character per beat.
// ----------------------------------------------------------------------------
module upe_back import upe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    head_i,
  input  q_stat_t q_stat_i,
  output logic    pop_o,
  upe_out_if.source out_o
);

  phase_e             phase_q, phase_d;
  logic               valid_q, valid_d;
  logic               load;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;
  logic               drop_q, drop_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  assign load = !valid_q || out_o.ready;

  // next beat from the queue head
  always_comb begin
    char_d  = head_i.data;
    last_d  = 1'b1;
    drop_d  = 1'b0;
    total_d = head_i.total1;
    unique case (head_i.kind)
      CMD_DROP: begin
        char_d = CHAR_NUL;
        drop_d = 1'b1;
      end
      CMD_ENCODE: begin
        unique case (phase_q)
          PH_PCT: begin
            char_d = CHAR_PCT;
            last_d = 1'b0;
          end
          PH_HI: begin
            char_d  = hex_char(head_i.data[7:4] & NIBBLE_MASK);
            last_d  = 1'b0;
            total_d = head_i.total2;
          end
          PH_LO: begin
            char_d  = hex_char(head_i.data[3:0] & NIBBLE_MASK);
            total_d = head_i.total3;
          end
          default: begin
            char_d = CHAR_PCT;
            last_d = 1'b0;
          end
        endcase
      end
      default: begin
        char_d = head_i.data;
      end
    endcase
  end

  // sequencing
  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        if (last_d) begin
          pop_o   = 1'b1;
          phase_d = PH_PCT;
        end else begin
          unique case (phase_q)
            PH_PCT:  phase_d = PH_HI;
            PH_HI:   phase_d = PH_LO;
            default: phase_d = PH_PCT;
          endcase
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PH_PCT;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load && !q_stat_i.empty) begin
      char_q  <= char_d;
      last_q  <= last_d;
      drop_q  <= drop_d;
      total_q <= total_d;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.out_char     = char_q;
  assign out_o.last_of_run  = last_q;
  assign out_o.dropped      = drop_q;
  assign out_o.stored_total = total_q;

endmodule

// File: rtl/url_percent_encoder_unit.sv
// ----------------------------------------------------------------------------
// url_percent_encoder_unit
// Percent encoder: one source byte in, one or three characters out.
// ----------------------------------------------------------------------------
// path: an accepted byte is written to the command queue, then loaded into the back end's output register
// throughput: one byte per cycle when passed or dropped and nothing stalls the output;
//   an encoded byte leaves as three characters through the one-character result register of the back end
// reset: stored count cleared, command queue empty, output idle,
//   registers back to mode normal, by-line off, capacity 1024
module url_percent_encoder_unit import upe_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  upe_cfg_if.sink    cfg_i,
  upe_in_if.sink     in_i,
  upe_out_if.source  out_o
);

  cfg_t    cfg_q;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;
  q_stat_t q_stat;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.encode_mode <= MODE_NORMAL;
      cfg_q.by_line     <= 1'b0;
      cfg_q.capacity    <= CAPACITY_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_ENCODE_MODE: cfg_q.encode_mode <= cfg_i.data[MODE_W-1:0];
        CFG_BY_LINE:     cfg_q.by_line     <= cfg_i.data[0];
        CFG_CAPACITY:    cfg_q.capacity    <= cfg_i.data[CAP_W-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // front end: accept and classify
  upe_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // command queue
  upe_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  // back end: emit characters
  upe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // a drop beat is a single zero character
  a_drop_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.dropped |-> out_o.last_of_run && out_o.out_char == CHAR_NUL)
    else $error("drop beat not single zero character");

  // input stalls only when the queue is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q_stat.full)
    else $error("input stalled with room in queue");

  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a non-last beat of a run is followed by another beat of that run
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_of_run |=> out_o.valid)
    else $error("encoded run broken");

endmodule
